[rtl/nsf_pkg.sv]
// Shared types, codes and decode functions of the NMEA sentence framer.
package nsf_pkg;

  localparam int unsigned MAX_LEN_DEF = 128;
  localparam int unsigned HDR_LEN     = 5;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [2:0] kind_t;

  localparam status_t ST_INCOMPLETE = 2'd0;
  localparam status_t ST_VALID      = 2'd1;
  localparam status_t ST_INVALID    = 2'd2;
  localparam status_t ST_OVERFLOW   = 2'd3;

  localparam kind_t KIND_NONE = 3'd0;
  localparam kind_t KIND_GGA  = 3'd1;
  localparam kind_t KIND_RMC  = 3'd2;
  localparam kind_t KIND_GST  = 3'd3;
  localparam kind_t KIND_GSV  = 3'd4;
  localparam kind_t KIND_GSA  = 3'd5;

  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_UA     = 8'h41;
  localparam byte_t CH_UF     = 8'h46;
  localparam byte_t CH_LA     = 8'h61;
  localparam byte_t CH_LF_HEX = 8'h66;
  localparam byte_t CH_G      = 8'h47;
  localparam byte_t CH_R      = 8'h52;
  localparam byte_t CH_M      = 8'h4D;
  localparam byte_t CH_C      = 8'h43;
  localparam byte_t CH_S      = 8'h53;
  localparam byte_t CH_T      = 8'h54;
  localparam byte_t CH_V      = 8'h56;
  localparam byte_t CH_A      = 8'h41;

  // Item held in the input register.
  typedef struct packed {
    logic  valid;
    byte_t rx_byte;
  } in_item_t;

  // Hex digit value in [3:0], bit 4 set when the byte is not a hex digit.
  function automatic logic [4:0] hex_digit(input byte_t b);
    logic [4:0] d;
    if (b >= CH_0 && b <= CH_9) begin
      d = {1'b0, 4'(b - CH_0)};
    end else if (b >= CH_UA && b <= CH_UF) begin
      d = {1'b0, 4'(b - CH_UA + 8'd10)};
    end else if (b >= CH_LA && b <= CH_LF_HEX) begin
      d = {1'b0, 4'(b - CH_LA + 8'd10)};
    end else begin
      d = 5'h10;
    end
    return d;
  endfunction

  // Sentence type from talker letter and the three type letters.
  function automatic kind_t decode_kind(input byte_t t0, input byte_t a,
                                        input byte_t b, input byte_t c);
    kind_t k;
    k = KIND_NONE;
    if (t0 == CH_G) begin
      if (a == CH_G && b == CH_G && c == CH_A)      k = KIND_GGA;
      else if (a == CH_R && b == CH_M && c == CH_C) k = KIND_RMC;
      else if (a == CH_G && b == CH_S && c == CH_T) k = KIND_GST;
      else if (a == CH_G && b == CH_S && c == CH_V) k = KIND_GSV;
      else if (a == CH_G && b == CH_S && c == CH_A) k = KIND_GSA;
    end
    return k;
  endfunction

endpackage

[rtl/nsf_if.sv]
// Valid/ready channel interfaces for received bytes and framer results.
interface nsf_in_if;
  import nsf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_out_if;
  import nsf_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  kind_t   sentence_kind;
  modport source (output valid, output status, output sentence_kind, input ready);
  modport sink   (input valid, input status, input sentence_kind, output ready);
endinterface

[rtl/nsf_in_stage.sv]
// Input register: holds one received byte until the parser takes it.
module nsf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  nsf_pkg::byte_t    in_byte,
  output logic              in_ready,
  input  logic              take,
  output nsf_pkg::in_item_t item
);
  import nsf_pkg::*;

  logic  valid_r, valid_nxt;
  byte_t byte_r;

  // free slot or the held item leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;
endmodule

[rtl/nsf_parser.sv]
// Framing state, running checksum, header capture and result register.
module nsf_parser #(
  parameter int unsigned MAX_LEN = nsf_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nsf_pkg::in_item_t item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output nsf_pkg::status_t  out_status,
  output nsf_pkg::kind_t    out_kind
);
  import nsf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_CKH  = 3'd2;
  localparam logic [2:0] PH_CKL  = 3'd3;
  localparam logic [2:0] PH_CR   = 3'd4;
  localparam logic [2:0] PH_LF   = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t            xor_r, xor_nxt;
  logic [3:0]       hi_r, hi_nxt;
  byte_t            hdr_r [HDR_LEN];
  logic             hdr_we;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  kind_t            kind_r, kind_nxt;
  logic             step;
  logic [4:0]       dig;
  byte_t            b;

  assign take = !out_valid_r || out_ready;
  assign step = take && item.valid;
  assign b    = item.rx_byte;
  assign dig  = hex_digit(b);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    xor_nxt    = xor_r;
    hi_nxt     = hi_r;
    hdr_we     = 1'b0;
    status_nxt = ST_INCOMPLETE;
    kind_nxt   = KIND_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (b == CH_DOLLAR) begin
          cnt_nxt   = '0;
          xor_nxt   = '0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (b == CH_STAR) begin
          phase_nxt = PH_CKH;
        end else if (b == CH_CR || b == CH_LF) begin
          phase_nxt  = PH_IDLE;
          status_nxt = ST_INVALID;
        end else if (cnt_r < CNT_W'(MAX_LEN - 1)) begin
          hdr_we  = (cnt_r < CNT_W'(HDR_LEN));
          cnt_nxt = cnt_r + 1'b1;
          xor_nxt = xor_r ^ b;
        end else begin
          phase_nxt  = PH_IDLE;
          status_nxt = ST_OVERFLOW;
        end
      end
      PH_CKH: begin
        if (dig[4]) begin
          phase_nxt  = PH_IDLE;
          status_nxt = ST_INVALID;
        end else begin
          hi_nxt    = dig[3:0];
          phase_nxt = PH_CKL;
        end
      end
      PH_CKL: begin
        if (dig[4]) begin
          phase_nxt  = PH_IDLE;
          status_nxt = ST_INVALID;
        end else begin
          phase_nxt = PH_CR;
          if ({hi_r, dig[3:0]} == xor_r) begin
            status_nxt = ST_VALID;
            // short sentence: header incomplete, no type
            if (cnt_r >= CNT_W'(HDR_LEN)) begin
              kind_nxt = decode_kind(hdr_r[0], hdr_r[2], hdr_r[3], hdr_r[4]);
            end
          end else begin
            status_nxt = ST_INVALID;
          end
        end
      end
      PH_CR: begin
        phase_nxt = (b == CH_CR) ? PH_LF : PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      xor_r       <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        xor_r   <= xor_nxt;
        hi_r    <= hi_nxt;
      end
      if (take) begin
        out_valid_r <= item.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr_r[cnt_r[2:0]] <= b;
    end
    if (step) begin
      status_r <= status_nxt;
      kind_r   <= kind_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_kind   = kind_r;
endmodule

[rtl/nmea_sentence_framer_unit.sv]
// Top level of the NMEA sentence framer.
// Takes one received byte per item and gives one result item per byte:
// status (incomplete, valid, invalid checksum/framing, overflow) and the
// sentence type (GGA, RMC, GST, GSV, GSA with talker G) on a valid sentence.
// A byte goes through an input register and a result register before its
// result is shown. Both stages advance together, and the block takes a
// new byte every cycle while the result side keeps up.
// The rate is set by the single framing-state update between the two
// registers. in_ch.ready depends combinationally on out_ch.ready.
// MAX_LEN bounds the stored data bytes at MAX_LEN - 1; the next data byte
// reports overflow. No reset-time clearing pass is needed.
module nmea_sentence_framer_unit #(
  parameter int unsigned MAX_LEN = nsf_pkg::MAX_LEN_DEF
) (
  input logic    clk,
  input logic    rst_n,
  nsf_in_if.sink   in_ch,
  nsf_out_if.source out_ch
);
  import nsf_pkg::*;

  in_item_t item;
  logic     take;

  // input register
  nsf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .take     (take),
    .item     (item)
  );

  // state update and result register
  nsf_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .take       (take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_kind   (out_ch.sentence_kind)
  );
endmodule

[rtl/nsf_checker.sv]
// Port-level checks of the framer's result channel, bound to the top level.
module nsf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input nsf_pkg::status_t out_status,
  input nsf_pkg::kind_t   out_kind
);
  import nsf_pkg::*;

  a_kind_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_NONE || out_status == ST_VALID))
    else $error("sentence type given without a valid status");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_GSA))
    else $error("sentence type code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_kind))
    else $error("stalled result changed");
endmodule

bind nmea_sentence_framer_unit nsf_checker u_nsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_kind   (out_ch.sentence_kind)
);
